FILE: hdl/size_class_page_allocator_top_macros.svh
// Assertion macros for the allocator
`ifndef SIZE_CLASS_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_PAGE_ALLOCATOR_TOP_MACROS_SVH
// a implies b on the same edge
`define SCPA_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// a implies b in the next cycle
`define SCPA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

FILE: hdl/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Constants, types and helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package scpa_pkg;
	localparam int NumPages   = 8;
	localparam int PageBytes  = 4096;
	localparam int MinBlock   = 16;
	localparam int NumClasses = 9;
	localparam int StoreDepth = NumPages * (PageBytes / MinBlock);
	localparam int AddrW  = 15;
	localparam int ReqW   = 13;
	localparam int IdxW   = $clog2(StoreDepth);
	localparam int CntW   = IdxW + 1;
	localparam int ClsW   = $clog2(NumClasses + 1);
	localparam int PageW  = $clog2(NumPages);
	localparam int OffW   = $clog2(PageBytes);
	localparam int ArenaBytes = NumPages * PageBytes;

	typedef logic [2:0] status_t;
	localparam status_t StOk       = 3'd0;
	localparam status_t StZeroSize = 3'd1;
	localparam status_t StNoMem    = 3'd2;
	localparam status_t StBadAddr  = 3'd3;
	localparam status_t StOverflow = 3'd4;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OpAlloc  = 2'd0;
	localparam opcode_t OpFree   = 2'd1;
	localparam opcode_t OpInit   = 2'd2;
	localparam opcode_t OpUnused = 2'd3;

	// store write and read request from the controller
	typedef struct packed {
		logic            we;
		logic [IdxW-1:0] waddr;
		logic [AddrW-1:0] wdata;
		logic            re;
		logic [IdxW-1:0] raddr;
	} mem_req_t;

	function automatic logic [ClsW-1:0] page_class(input logic [31:0] cfg,
		input logic [PageW-1:0] page);
		logic [3:0] code;
		code = cfg[{page, 2'b00} +: 4];
		if (32'(code) > NumClasses - 1) page_class = ClsW'(NumClasses - 1);
		else page_class = ClsW'(code);
	endfunction

	// blocks of a class in one page (0 when the block exceeds a page)
	function automatic logic [CntW-1:0] blocks_per_page(input logic [ClsW-1:0] cls);
		logic [31:0] bs;
		bs = 32'(MinBlock) << cls;
		if (bs > 32'(PageBytes)) blocks_per_page = '0;
		else blocks_per_page = CntW'((PageBytes / MinBlock) >> cls);
	endfunction
endpackage
`default_nettype wire

FILE: hdl/scpa_store.sv
// ----------------------------------------------------------------------------
// scpa_store
// Free list store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module scpa_store (
	input  wire                        clk,
	input  scpa_pkg::mem_req_t         req,
	output logic [scpa_pkg::AddrW-1:0] rdata
);
	logic [scpa_pkg::AddrW-1:0] mem [scpa_pkg::StoreDepth];

	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		if (req.re) rdata <= mem[req.raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/scpa_ctrl.sv
// ----------------------------------------------------------------------------
// scpa_ctrl
// Class tables and sequencer: allocate, free and the init walk.
// ----------------------------------------------------------------------------
`default_nettype none
module scpa_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [1:0]                  opcode,
	input  wire  [scpa_pkg::ReqW-1:0]   request_bytes,
	input  wire  [scpa_pkg::AddrW-1:0]  block_address,
	input  wire  [31:0]                 cfg,
	input  wire  [scpa_pkg::AddrW-1:0]  rdata,
	output scpa_pkg::mem_req_t          mreq,
	output logic                        busy,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [scpa_pkg::AddrW-1:0]  granted_address
);
	localparam int CW = scpa_pkg::ClsW;
	localparam int NW = scpa_pkg::CntW;
	localparam int IW = scpa_pkg::IdxW;
	localparam int NC = scpa_pkg::NumClasses;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_SIZE  = 5'b00100,
		S_FILL  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic [NW-1:0] head_q [NC];
	logic [NW-1:0] cnt_q  [NC];
	logic [NW-1:0] base_q [NC];
	logic [NW-1:0] size_q [NC];
	logic [CW-1:0] cls_q;
	logic [NW-1:0] run_q;
	logic [scpa_pkg::PageW:0] page_q;
	logic [NW-1:0] blk_q;
	logic [2:0] status_q;
	logic [scpa_pkg::AddrW-1:0] grant_q;
	logic done_q;

	// allocate: smallest fitting non-empty class
	logic          hit;
	logic [CW-1:0] hit_c;
	always_comb begin
		hit = 1'b0;
		hit_c = '0;
		for (int c = NC - 1; c >= 0; c--) begin
			if ((32'(scpa_pkg::MinBlock) << c) >= 32'(request_bytes) && cnt_q[c] != '0) begin
				hit = 1'b1;
				hit_c = CW'(c);
			end
		end
	end

	// free: page class and tail slot
	logic [CW-1:0] f_c;
	logic [NW:0]   f_pos;
	logic [NW-1:0] f_slot;
	logic [NW:0]   f_idx;
	always_comb begin
		f_c = scpa_pkg::page_class(cfg,
			block_address[scpa_pkg::OffW +: scpa_pkg::PageW]);
		f_pos = {1'b0, head_q[f_c]} + {1'b0, cnt_q[f_c]};
		if (f_pos >= {1'b0, size_q[f_c]}) f_pos = f_pos - {1'b0, size_q[f_c]};
		f_slot = f_pos[NW-1:0];
		f_idx = {1'b0, base_q[f_c]} + {1'b0, f_slot};
	end

	logic free_ok;
	assign free_ok = cnt_q[f_c] < size_q[f_c] && f_idx < (NW+1)'(scpa_pkg::StoreDepth);

	logic [scpa_pkg::PageW-1:0] pg;
	logic [CW-1:0] pc;
	logic [NW-1:0] pbl;
	assign pg = page_q[scpa_pkg::PageW-1:0];
	assign pc = scpa_pkg::page_class(cfg, pg);
	assign pbl = scpa_pkg::blocks_per_page(pc);

	logic [NW:0] a_idx;
	assign a_idx = {1'b0, base_q[hit_c]} + {1'b0, head_q[hit_c]};

	always_comb begin
		mreq = '0;
		if (state_q == S_IDLE && start && opcode == scpa_pkg::OpAlloc) begin
			mreq.re = 1'b1;
			mreq.raddr = a_idx[IW-1:0];
		end
		if (state_q == S_IDLE && start && opcode == scpa_pkg::OpFree
			&& 32'(block_address) < 32'(scpa_pkg::ArenaBytes) && free_ok) begin
			mreq.we = 1'b1;
			mreq.waddr = f_idx[IW-1:0];
			mreq.wdata = block_address;
		end
		if (state_q == S_FILL && blk_q < pbl) begin
			mreq.we = 1'b1;
			mreq.waddr = IW'(base_q[pc] + cnt_q[pc]);
			mreq.wdata = scpa_pkg::AddrW'((32'(pg) * scpa_pkg::PageBytes)
				+ (32'(blk_q) << (pc + CW'($clog2(scpa_pkg::MinBlock)))));
		end
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			for (int c = 0; c < NC; c++) begin
				head_q[c] <= '0; cnt_q[c] <= '0; base_q[c] <= '0; size_q[c] <= '0;
			end
			cls_q <= '0; run_q <= '0; page_q <= '0; blk_q <= '0;
			status_q <= '0; grant_q <= '0;
		end else begin
			done_q <= (state_q == S_DONE);
			case (state_q)
				S_IDLE: if (start) begin
					grant_q <= '0;
					case (opcode)
						scpa_pkg::OpAlloc: begin
							if (request_bytes == '0) begin
								status_q <= scpa_pkg::StZeroSize;
								state_q <= S_DONE;
							end else if (!hit) begin
								status_q <= scpa_pkg::StNoMem;
								state_q <= S_DONE;
							end else begin
								status_q <= scpa_pkg::StOk;
								if (head_q[hit_c] + 1'b1 >= size_q[hit_c]) head_q[hit_c] <= '0;
								else head_q[hit_c] <= head_q[hit_c] + 1'b1;
								cnt_q[hit_c] <= cnt_q[hit_c] - 1'b1;
								// store index beyond depth reads as zero
								cls_q <= CW'(a_idx < (NW+1)'(scpa_pkg::StoreDepth));
								state_q <= S_READ;
							end
						end
						scpa_pkg::OpFree: begin
							if (32'(block_address) >= 32'(scpa_pkg::ArenaBytes))
								status_q <= scpa_pkg::StBadAddr;
							else if (!free_ok) status_q <= scpa_pkg::StOverflow;
							else begin
								status_q <= scpa_pkg::StOk;
								cnt_q[f_c] <= cnt_q[f_c] + 1'b1;
							end
							state_q <= S_DONE;
						end
						scpa_pkg::OpInit: begin
							status_q <= scpa_pkg::StOk;
							cls_q <= '0; run_q <= '0; page_q <= '0;
							state_q <= S_SIZE;
						end
						default: begin
							status_q <= scpa_pkg::StOk;
							state_q <= S_DONE;
						end
					endcase
				end
				S_READ: begin
					grant_q <= cls_q[0] ? rdata : '0;
					state_q <= S_DONE;
				end
				// one page per cycle per class: region sizes and bases
				S_SIZE: begin
					if (page_q == (scpa_pkg::PageW+1)'(scpa_pkg::NumPages)) begin
						base_q[cls_q] <= run_q - size_q[cls_q];
						head_q[cls_q] <= '0;
						cnt_q[cls_q] <= '0;
						page_q <= '0;
						if (cls_q == CW'(NC - 1)) begin
							blk_q <= '0;
							state_q <= S_FILL;
						end else cls_q <= cls_q + 1'b1;
					end else begin
						if (page_q == '0) begin
							size_q[cls_q] <= (pc == cls_q) ? pbl : '0;
							run_q <= run_q + ((pc == cls_q) ? pbl : '0);
						end else if (pc == cls_q) begin
							size_q[cls_q] <= size_q[cls_q] + pbl;
							run_q <= run_q + pbl;
						end
						page_q <= page_q + 1'b1;
					end
				end
				// one block per cycle
				S_FILL: begin
					if (blk_q < pbl) begin
						cnt_q[pc] <= cnt_q[pc] + 1'b1;
						blk_q <= blk_q + 1'b1;
					end else begin
						blk_q <= '0;
						if (pg == scpa_pkg::PageW'(scpa_pkg::NumPages - 1)) state_q <= S_DONE;
						page_q <= page_q + 1'b1;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign granted_address = grant_q;
endmodule
`default_nettype wire

FILE: hdl/size_class_page_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_page_allocator_top
// Size class page allocator with FIFO free lists in one block store.
// ----------------------------------------------------------------------------
// channel   | handshake            | fields
// command   | start & !busy        | opcode, request_bytes, block_address
// result    | done (one cycle)     | status, granted_address
// config    | cfg_we               | cfg_wdata
// Allocate goes through search, store read and result. Free and errors
// go straight to the result. Init walks the class tables page by page
// for each class, then writes every block of every page into the store.
// Reset clears class tables; the store is not cleared. Results cannot stall.
`default_nettype none
`include "size_class_page_allocator_top_macros.svh"
module size_class_page_allocator_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  opcode,
	input  wire  [12:0] request_bytes,
	input  wire  [14:0] block_address,
	input  wire         cfg_we,
	input  wire  [31:0] cfg_wdata,
	output logic        done,
	output logic [2:0]  status,
	output logic [14:0] granted_address
);
	logic [31:0] cfg_q;
	scpa_pkg::mem_req_t mreq;
	logic [scpa_pkg::AddrW-1:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cfg_q <= '0;
		else if (cfg_we) cfg_q <= cfg_wdata;
	end

	scpa_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

	scpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.request_bytes(request_bytes), .block_address(block_address),
		.cfg(cfg_q), .rdata(rdata), .mreq(mreq), .busy(busy), .done(done),
		.status(status), .granted_address(granted_address)
	);

	`SCPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not set busy")
	`SCPA_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !done, "done longer than one cycle")
	`SCPA_ASSERT_IMP(a_grant_ok, clk, arst_n, done && status != scpa_pkg::StOk, granted_address == '0, "address on error")
endmodule
`default_nettype wire
